/* design/qgdp_pkg.sv */
// ----------------------------------------------------------------------------
// Quantized group dot product package
// Shared widths, constants and the queue entry type of the block.
// ----------------------------------------------------------------------------
package qgdp_pkg;

  localparam int LANES       = 8;
  localparam int WGT_W       = 4;
  localparam int ACT_W       = 16;
  localparam int PW_W        = 32;
  localparam int PROD_W      = WGT_W + ACT_W;
  localparam int PSUM_W      = PROD_W + $clog2(LANES);
  localparam int SUM_W       = 26;
  localparam int QUEUE_DEPTH = 2;

  localparam int GROUP_ELEMS_DEFAULT = 64;

  localparam logic FMT_INT4 = 1'b0;
  localparam logic FMT_INT3 = 1'b1;

  localparam logic [WGT_W-1:0] INT3_OFFSET = 4'd4;

  typedef struct packed {
    logic [LANES-1:0][WGT_W-1:0] weights;
    logic [LANES-1:0][ACT_W-1:0] acts;
    logic                        last;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

endpackage

/* design/qgdp_front.sv */
// ----------------------------------------------------------------------------
// Quantized group dot product front end
// Accepts input transactions, decodes the packed weights in the current
// format and marks the chunk that closes a group.
// ----------------------------------------------------------------------------
module qgdp_front #(
  parameter int GROUP_ELEMS = qgdp_pkg::GROUP_ELEMS_DEFAULT
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 cfg_we,
  input  logic                                                 cfg_wdata,
  input  logic                                                 item_valid,
  output logic                                                 item_stall,
  input  logic [qgdp_pkg::PW_W-1:0]                            packed_weights,
  input  logic [qgdp_pkg::LANES-1:0][qgdp_pkg::ACT_W-1:0]      acts,
  input  logic                                                 queue_full,
  output qgdp_pkg::push_t                                      push
);

  localparam int CHUNKS = GROUP_ELEMS / qgdp_pkg::LANES;
  localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  logic             weight_format;
  logic [CNT_W-1:0] chunk_count;
  logic             accept;
  logic             last;

  logic [qgdp_pkg::LANES-1:0][qgdp_pkg::WGT_W-1:0] weights;

  assign item_stall = queue_full;
  assign accept     = item_valid && !queue_full;
  assign last       = (chunk_count == CNT_W'(CHUNKS - 1));

  always_comb begin
    for (int j = 0; j < qgdp_pkg::LANES; j++) begin
      case (weight_format)
        qgdp_pkg::FMT_INT4: begin
          weights[j] = packed_weights[qgdp_pkg::WGT_W*j +: qgdp_pkg::WGT_W];
        end
        qgdp_pkg::FMT_INT3: begin
          weights[j] = {1'b0, packed_weights[16 + j], packed_weights[2*j +: 2]}
                       - qgdp_pkg::INT3_OFFSET;
        end
        default: begin
          weights[j] = '0;
        end
      endcase
    end
  end

  assign push.valid         = accept;
  assign push.entry.weights = weights;
  assign push.entry.acts    = acts;
  assign push.entry.last    = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_format <= qgdp_pkg::FMT_INT4;
      chunk_count   <= '0;
    end else begin
      if (cfg_we) begin
        weight_format <= cfg_wdata;
      end
      if (accept) begin
        chunk_count <= last ? '0 : chunk_count + CNT_W'(1);
      end
    end
  end

  a_group_wraps: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (chunk_count == '0))
    else $error("Chunk counter did not restart after the closing chunk.");

endmodule

/* design/qgdp_queue.sv */
// ----------------------------------------------------------------------------
// Quantized group dot product queue
// Short FIFO of decoded chunks between the front end and the datapath.
// ----------------------------------------------------------------------------
module qgdp_queue (
  input  logic             clk,
  input  logic             rst,
  input  qgdp_pkg::push_t  push,
  output logic             full,
  output logic             pop_valid,
  output qgdp_pkg::entry_t pop_entry,
  input  logic             pop
);

  localparam int PTR_W = $clog2(qgdp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(qgdp_pkg::QUEUE_DEPTH + 1);

  qgdp_pkg::entry_t mem [qgdp_pkg::QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(qgdp_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = mem[rd_ptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(qgdp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(qgdp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(qgdp_pkg::QUEUE_DEPTH))
    else $error("Queue occupancy exceeds its depth.");

endmodule

/* design/qgdp_back.sv */
// ----------------------------------------------------------------------------
// Quantized group dot product datapath
// Multiplies eight lanes, sums them, accumulates the group with saturation
// and holds the finished sum in the output register.
// ----------------------------------------------------------------------------
module qgdp_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    pop_valid,
  input  qgdp_pkg::entry_t                        pop_entry,
  output logic                                    pop,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output logic signed [qgdp_pkg::SUM_W-1:0]       dot_sum
);

  localparam int LANES  = qgdp_pkg::LANES;
  localparam int PROD_W = qgdp_pkg::PROD_W;
  localparam int PSUM_W = qgdp_pkg::PSUM_W;
  localparam int SUM_W  = qgdp_pkg::SUM_W;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic                     s1_valid;
  logic                     s1_last;
  logic signed [PROD_W-1:0] s1_prod [LANES];
  logic                     s1_ready;

  logic                     s2_valid;
  logic                     s2_last;
  logic signed [PSUM_W-1:0] s2_psum;
  logic                     s2_ready;

  logic signed [PSUM_W-1:0] psum;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W:0]    acc_wide;
  logic signed [SUM_W-1:0]  acc_next;
  logic                     acc_ready;
  logic                     acc_fire;

  assign acc_ready = !s2_last || !result_valid || !result_stall;
  assign acc_fire  = s2_valid && acc_ready;
  assign s2_ready  = !s2_valid || acc_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign pop       = pop_valid && s1_ready;

  always_comb begin
    psum = '0;
    for (int i = 0; i < LANES; i++) begin
      psum = psum + PSUM_W'(s1_prod[i]);
    end
  end

  always_comb begin
    acc_wide = {acc[SUM_W-1], acc} + (SUM_W+1)'(s2_psum);
    if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
      acc_next = acc_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      acc_next = acc_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_last <= pop_entry.last;
      for (int i = 0; i < LANES; i++) begin
        s1_prod[i] <= $signed(pop_entry.weights[i]) * $signed(pop_entry.acts[i]);
      end
    end
    if (s2_ready) begin
      s2_last <= s1_last;
      s2_psum <= psum;
    end
    if (acc_fire && s2_last) begin
      dot_sum <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      acc          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pop_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (acc_fire) begin
        acc <= s2_last ? '0 : acc_next;
      end
      if (acc_fire && s2_last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (acc_fire && s2_last) |=> (acc == '0))
    else $error("Accumulator did not clear after a group closed.");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (acc_fire && s2_last) |=> result_valid)
    else $error("Closing chunk did not produce a result.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !(acc_fire && s2_last))
    else $error("Pending result overwritten by a new group sum.");

endmodule

/* design/quantized_group_dot_product.sv */
// ----------------------------------------------------------------------------
// Quantized group dot product
// Dot product of a group of packed INT4 or INT3 weights with signed 16-bit
// activations, eight elements per transaction.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock cycle while the queue is
// not full, each carrying one 32-bit word of packed weights and eight
// activations, and returns one dot_sum transaction after every GROUP_ELEMS/8
// inputs. The front end decodes the weights with the format in force when the
// transaction is accepted and writes the chunk into a two-entry queue; the
// datapath behind it registers eight 4x16 products, then their sum, then adds
// that sum into the saturating group accumulator. A result is registered in
// dot_sum when its closing chunk leaves the accumulator stage, and a stalled
// result holds only the closing chunk of the next group, so the other chunks
// keep flowing until that closing chunk reaches the accumulator.
module quantized_group_dot_product #(
  parameter int GROUP_ELEMS = qgdp_pkg::GROUP_ELEMS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic                                  cfg_wdata,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic        [qgdp_pkg::PW_W-1:0]      packed_weights,
  input  logic signed [qgdp_pkg::ACT_W-1:0]     act_0,
  input  logic signed [qgdp_pkg::ACT_W-1:0]     act_1,
  input  logic signed [qgdp_pkg::ACT_W-1:0]     act_2,
  input  logic signed [qgdp_pkg::ACT_W-1:0]     act_3,
  input  logic signed [qgdp_pkg::ACT_W-1:0]     act_4,
  input  logic signed [qgdp_pkg::ACT_W-1:0]     act_5,
  input  logic signed [qgdp_pkg::ACT_W-1:0]     act_6,
  input  logic signed [qgdp_pkg::ACT_W-1:0]     act_7,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [qgdp_pkg::SUM_W-1:0]     dot_sum
);

  logic [qgdp_pkg::LANES-1:0][qgdp_pkg::ACT_W-1:0] acts;

  qgdp_pkg::push_t  push;
  qgdp_pkg::entry_t pop_entry;
  logic             queue_full;
  logic             pop_valid;
  logic             pop;

  assign acts = {act_7, act_6, act_5, act_4, act_3, act_2, act_1, act_0};

  qgdp_front #(
    .GROUP_ELEMS (GROUP_ELEMS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .packed_weights (packed_weights),
    .acts           (acts),
    .queue_full     (queue_full),
    .push           (push)
  );

  qgdp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (queue_full),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop)
  );

  qgdp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_entry    (pop_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .dot_sum      (dot_sum)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quantized group dot product testbench
// Sends chunks of packed INT4 and INT3 weights with activations to the block.
// A directed set of groups comes first, then random phases that change the
// weight format, sometimes in the middle of a group. Both sides of the block
// idle and stall at random. Each dot_sum is compared with a group-sum
// predictor, or with a hand-computed value for the simple directed groups.
// ----------------------------------------------------------------------------
module tb;

  localparam int LANES = qgdp_pkg::LANES;
  localparam int ACT_W = qgdp_pkg::ACT_W;
  localparam int PW_W  = qgdp_pkg::PW_W;
  localparam int SUM_W = qgdp_pkg::SUM_W;
  localparam int CHUNKS_PER_GROUP = qgdp_pkg::GROUP_ELEMS_DEFAULT / LANES;
  localparam longint SUM_HI = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -(longint'(1) << (SUM_W - 1));
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_CHUNKS = 750;

  typedef logic [LANES-1:0][ACT_W-1:0] act_vec_t;

  typedef struct {
    logic             fmt;
    logic [PW_W-1:0]  pw;
    act_vec_t         acts;
    int               reps;
    bit               known;
    int               known_sum;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_we;
  logic                     cfg_wdata;
  logic                     item_valid;
  logic                     item_stall;
  logic        [PW_W-1:0]   packed_weights;
  logic signed [ACT_W-1:0]  act_0, act_1, act_2, act_3, act_4, act_5, act_6, act_7;
  logic                     result_valid;
  logic                     result_stall;
  logic signed [SUM_W-1:0]  dot_sum;

  logic                     pred_format;
  longint                   group_acc;
  int                       chunks_in_group;
  logic signed [SUM_W-1:0]  pending_sums[$];
  logic signed [SUM_W-1:0]  head_sum;
  int                       errors;
  bit                       quiet;
  int                       stall_run;
  int                       stall_roll;
  dir_row_t                 directed_rows[5];

  quantized_group_dot_product dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .packed_weights (packed_weights),
    .act_0          (act_0),
    .act_1          (act_1),
    .act_2          (act_2),
    .act_3          (act_3),
    .act_4          (act_4),
    .act_5          (act_5),
    .act_6          (act_6),
    .act_7          (act_7),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .dot_sum        (dot_sum)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int weight_of_lane(input logic [PW_W-1:0] pw, input int lane,
                                        input logic fmt);
    logic [2:0] code;
    if (fmt == qgdp_pkg::FMT_INT4) begin
      return int'($signed(pw[4*lane +: 4]));
    end
    code = {pw[16+lane], pw[2*lane +: 2]};
    return int'(code) - 4;
  endfunction

  function automatic void accumulate_chunk(input logic [PW_W-1:0] pw, input act_vec_t acts,
                                           output bit closed,
                                           output logic signed [SUM_W-1:0] sum);
    longint acc;
    acc = group_acc;
    for (int j = 0; j < LANES; j++) begin
      acc += longint'(weight_of_lane(pw, j, pred_format)) * longint'($signed(acts[j]));
    end
    if (acc > SUM_HI) acc = SUM_HI;
    if (acc < SUM_LO) acc = SUM_LO;
    group_acc = acc;
    chunks_in_group++;
    closed = (chunks_in_group >= CHUNKS_PER_GROUP);
    sum = acc[SUM_W-1:0];
    if (closed) begin
      group_acc = 0;
      chunks_in_group = 0;
    end
  endfunction

  task automatic send_chunk(input logic [PW_W-1:0] pw, input act_vec_t acts,
                            input bit use_known, input int known_sum);
    int gap;
    int roll;
    bit closed;
    logic signed [SUM_W-1:0] sum;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(11, 30);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid     <= 1'b1;
    packed_weights <= pw;
    act_0 <= acts[0];
    act_1 <= acts[1];
    act_2 <= acts[2];
    act_3 <= acts[3];
    act_4 <= acts[4];
    act_5 <= acts[5];
    act_6 <= acts[6];
    act_7 <= acts[7];
    do @(posedge clk); while (item_stall);
    accumulate_chunk(pw, acts, closed, sum);
    if (closed) pending_sums.push_back(use_known ? known_sum[SUM_W-1:0] : sum);
  endtask

  // The block is drained and given time to settle before the format changes.
  task automatic set_format(input logic fmt);
    item_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= fmt;
    @(posedge clk);
    cfg_we      <= 1'b0;
    pred_format = fmt;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected dot_sum transaction, expected none, got %0d",
                 $time, dot_sum);
      end else begin
        head_sum = pending_sums.pop_front();
        if (dot_sum !== head_sum) begin
          errors++;
          $display("%0t: dot_sum mismatch, expected %0d, got %0d", $time, head_sum, dot_sum);
        end
      end
    end
    if (quiet) begin
      stall_run = 0;
      result_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      result_stall <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 65) begin
        result_stall <= 1'b0;
      end else begin
        stall_run = (stall_roll < 95) ? $urandom_range(0, 3) : $urandom_range(4, 30);
        result_stall <= 1'b1;
      end
    end
  end

  initial begin
    logic [PW_W-1:0] pw;
    act_vec_t        acts;
    int              roll;
    int              sent;
    int              phase_len;
    int              guard;
    errors          = 0;
    quiet           = 0;
    stall_run       = 0;
    pred_format     = qgdp_pkg::FMT_INT4;
    group_acc       = 0;
    chunks_in_group = 0;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 1'b0;
    item_valid     <= 1'b0;
    result_stall   <= 1'b0;
    packed_weights <= '0;
    act_0 <= '0;
    act_1 <= '0;
    act_2 <= '0;
    act_3 <= '0;
    act_4 <= '0;
    act_5 <= '0;
    act_6 <= '0;
    act_7 <= '0;

    directed_rows[0] = '{qgdp_pkg::FMT_INT4, 32'h8888_8888, {LANES{16'h8000}},
                         8, 1'b1, 16777216};
    directed_rows[1] = '{qgdp_pkg::FMT_INT4, 32'h8888_8888, {LANES{16'h7FFF}},
                         4, 1'b0, 0};
    directed_rows[2] = '{qgdp_pkg::FMT_INT3, 32'h0000_0000, {LANES{16'h7FFF}},
                         3, 1'b0, 0};
    directed_rows[3] = '{qgdp_pkg::FMT_INT3, 32'hFFFF_FFFF,
                         {16'h8001, 16'hEDCC, 16'h1234, 16'h0000,
                          16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF}, 1, 1'b0, 0};
    directed_rows[4] = '{qgdp_pkg::FMT_INT3, 32'hFFFF_FFFF, {LANES{16'h8000}},
                         8, 1'b1, -6291456};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_format(qgdp_pkg::FMT_INT4);

    // The second group switches from INT4 to INT3 halfway through.
    foreach (directed_rows[k]) begin
      if (directed_rows[k].fmt !== pred_format) set_format(directed_rows[k].fmt);
      for (int n = 0; n < directed_rows[k].reps; n++) begin
        send_chunk(directed_rows[k].pw, directed_rows[k].acts,
                   directed_rows[k].known && (n == directed_rows[k].reps - 1),
                   directed_rows[k].known_sum);
      end
    end

    sent = 0;
    while (sent < RANDOM_CHUNKS) begin
      quiet = ($urandom_range(0, 4) == 0);
      set_format(1'($urandom_range(0, 1)));
      phase_len = $urandom_range(24, 80);
      for (int i = 0; i < phase_len; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) pw = $urandom;
        else if (roll < 77) pw = 32'h0000_0000;
        else if (roll < 84) pw = 32'hFFFF_FFFF;
        else if (roll < 92) pw = 32'h8888_8888;
        else pw = 32'h7777_7777;
        for (int j = 0; j < LANES; j++) begin
          roll = $urandom_range(0, 99);
          if (roll < 60) acts[j] = 16'($urandom_range(0, 16'hFFFF));
          else if (roll < 68) acts[j] = 16'h8000;
          else if (roll < 76) acts[j] = 16'h7FFF;
          else if (roll < 80) acts[j] = 16'h0000;
          else if (roll < 84) acts[j] = 16'hFFFF;
          else acts[j] = 16'($signed($urandom_range(0, 31)) - 16);
        end
        send_chunk(pw, acts, 1'b0, 0);
        sent++;
      end
    end

    item_valid <= 1'b0;
    quiet = 0;
    for (guard = 0; guard < 5000 && pending_sums.size() != 0; guard++) @(posedge clk);
    if (pending_sums.size() != 0) begin
      errors += pending_sums.size();
      $display("%0t: %0d expected dot_sum transaction(s) never arrived, got none",
               $time, pending_sums.size());
    end
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** quantized_group_dot_product: PASSED **");
    end else begin
      $display("** quantized_group_dot_product: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** quantized_group_dot_product: FAILED **");
    $finish;
  end

endmodule
